// ----- src/socks_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers for the SOCKS5 client handshake block.
// No dependencies; the modules and the bench import this package.
package socks_pkg;

    // Longest credential that is ever sent, in bytes
    localparam int CRED_BYTES = 16;
    localparam int CRED_CAP   = (CRED_BYTES > 16) ? 16 : CRED_BYTES;

    // Two-entry job queue between front and back
    localparam int JOB_DEPTH  = 2;
    localparam int MAX_BEATS  = 35;

    // Handshake phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_GREET = 3'd1;
    localparam logic [2:0] PH_AUTH  = 3'd2;
    localparam logic [2:0] PH_REQ   = 3'd3;
    localparam logic [2:0] PH_EST   = 3'd4;
    localparam logic [2:0] PH_ERR   = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_VER   = 3'd2;
    localparam logic [2:0] ST_NO_METHOD = 3'd3;
    localparam logic [2:0] ST_UNSUPP    = 3'd4;
    localparam logic [2:0] ST_AUTH_FAIL = 3'd5;
    localparam logic [2:0] ST_REFUSED   = 3'd6;
    localparam logic [2:0] ST_BAD_PHASE = 3'd7;

    // Item modes
    localparam logic MODE_START = 1'b0;

    // Frame kinds carried through the queue
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_GREET = 2'd1;
    localparam logic [1:0] K_AUTH  = 2'd2;
    localparam logic [1:0] K_CONN  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_AUTH_OFFERED = 3'd0;
    localparam logic [2:0] REG_USER_LEN     = 3'd1;
    localparam logic [2:0] REG_USER_LO      = 3'd2;
    localparam logic [2:0] REG_USER_HI      = 3'd3;
    localparam logic [2:0] REG_PASS_LEN     = 3'd4;
    localparam logic [2:0] REG_PASS_LO      = 3'd5;
    localparam logic [2:0] REG_PASS_HI      = 3'd6;

    // Protocol bytes
    localparam logic [7:0] B_VER5     = 8'h05;
    localparam logic [7:0] B_ONE      = 8'h01;
    localparam logic [7:0] B_TWO      = 8'h02;
    localparam logic [7:0] B_ZERO     = 8'h00;
    localparam logic [7:0] B_NO_ACC   = 8'hFF;

    typedef struct packed {
        logic        mode;
        logic [7:0]  rx_first;
        logic [7:0]  rx_second;
        logic [7:0]  rx_count;
        logic [31:0] dst_ip;
        logic [15:0] dst_port_in;
    } cmd_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic [2:0] status;
        logic [2:0] phase;
        logic       connected;
    } res_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] wdata;
    } cfg_wr_t;

    typedef struct packed {
        logic        auth_offered;
        logic [4:0]  user_len;
        logic [63:0] user_lo;
        logic [63:0] user_hi;
        logic [4:0]  pass_len;
        logic [63:0] pass_lo;
        logic [63:0] pass_hi;
    } cfg_regs_t;

    // One queued item: which frame to send and the report fields
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [2:0]  phase;
        logic        connected;
        logic [31:0] ip;
        logic [15:0] port;
    } job_t;

    function automatic logic [4:0] clamp_len(input logic [4:0] len);
        logic [4:0] cap;
        cap = 5'(CRED_CAP);
        return (len > cap) ? cap : len;
    endfunction

endpackage

// ----- src/socks_stream_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload struct per beat.
// Payload type is set by the instantiating module from socks_pkg.
interface socks_stream_if #(parameter type data_t = logic) ();
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/socks_regs.sv -----
`timescale 1ns / 1ps
// Configuration register bank: auth offer, credential lengths and bytes.
// Depends on socks_pkg and socks_stream_if.
module socks_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    socks_stream_if.sink          cfg,
    output socks_pkg::cfg_regs_t  regs
);
    import socks_pkg::*;

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Register write decode
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.data.index)
                REG_AUTH_OFFERED: regs_next.auth_offered = cfg.data.wdata[0];
                REG_USER_LEN:     regs_next.user_len     = cfg.data.wdata[4:0];
                REG_USER_LO:      regs_next.user_lo      = cfg.data.wdata;
                REG_USER_HI:      regs_next.user_hi      = cfg.data.wdata;
                REG_PASS_LEN:     regs_next.pass_len     = cfg.data.wdata[4:0];
                REG_PASS_LO:      regs_next.pass_lo      = cfg.data.wdata;
                REG_PASS_HI:      regs_next.pass_hi      = cfg.data.wdata;
                default:          regs_next              = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            regs_reg <= '0;
        else
            regs_reg <= regs_next;
    end

endmodule

// ----- src/socks_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts items, judges replies against the phase, updates the
// handshake state and queues one job per item. Depends on socks_pkg.
module socks_front (
    input  logic                 clk,
    input  logic                 rst_n,
    socks_stream_if.sink         cmd,
    input  socks_pkg::cfg_regs_t regs,
    input  logic                 full,
    output logic                 push,
    output socks_pkg::job_t      job
);
    import socks_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic        greet_done_reg, greet_done_next;
    logic        auth_done_reg, auth_done_next;
    logic        req_done_reg, req_done_next;
    logic        conn_reg, conn_next;
    logic [31:0] ip_reg, ip_next;
    logic [15:0] port_reg, port_next;

    logic        go_conn;
    logic        go_auth;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  cnt;

    assign cmd.ready = !full;
    assign push      = cmd.valid && !full;
    assign b0        = cmd.data.rx_first;
    assign b1        = cmd.data.rx_second;
    assign cnt       = cmd.data.rx_count;

    // Classify the item and work out the next state
    always_comb
    begin
        phase_next      = phase_reg;
        greet_done_next = greet_done_reg;
        auth_done_next  = auth_done_reg;
        req_done_next   = req_done_reg;
        conn_next       = conn_reg;
        ip_next         = ip_reg;
        port_next       = port_reg;
        go_conn         = 1'b0;
        go_auth         = 1'b0;
        job.kind        = K_NONE;
        job.status      = ST_OK;

        if (push)
        begin
            if (cmd.data.mode == MODE_START)
            begin
                ip_next   = cmd.data.dst_ip;
                port_next = cmd.data.dst_port_in;
                if (!greet_done_reg)
                begin
                    job.kind        = K_GREET;
                    greet_done_next = 1'b1;
                    phase_next      = PH_GREET;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_GREET:
                    begin
                        if (cnt < 8'd2)
                            job.status = ST_SHORT;
                        else if (b0 != B_VER5)
                            job.status = ST_BAD_VER;
                        else if (b1 == B_NO_ACC)
                            job.status = ST_NO_METHOD;
                        else if (b1 == B_ZERO)
                            go_conn = 1'b1;
                        else if (b1 == B_TWO)
                            go_auth = 1'b1;
                        else
                            job.status = ST_UNSUPP;
                    end
                    PH_AUTH:
                    begin
                        if (cnt < 8'd2)
                            job.status = ST_SHORT;
                        else if (b0 != B_ONE)
                            job.status = ST_BAD_VER;
                        else if (b1 != B_ZERO)
                            job.status = ST_AUTH_FAIL;
                        else
                            go_conn = 1'b1;
                    end
                    PH_REQ:
                    begin
                        if (cnt < 8'd4)
                            job.status = ST_SHORT;
                        else if (b0 != B_VER5)
                            job.status = ST_BAD_VER;
                        else if (b1 != B_ZERO)
                        begin
                            job.status = ST_REFUSED;
                            phase_next = PH_ERR;
                        end
                        else
                        begin
                            phase_next = PH_EST;
                            conn_next  = 1'b1;
                        end
                    end
                    PH_EST:  job.status = ST_OK;
                    default: job.status = ST_BAD_PHASE;
                endcase
            end
        end

        // Connect frame goes out once only; the phase moves regardless
        if (go_conn)
        begin
            phase_next = PH_REQ;
            if (!req_done_reg)
            begin
                job.kind      = K_CONN;
                req_done_next = 1'b1;
            end
        end

        // Auth frame goes out once only and only with a username
        if (go_auth)
        begin
            phase_next = PH_AUTH;
            if (!auth_done_reg && (regs.user_len != 5'd0))
            begin
                job.kind       = K_AUTH;
                auth_done_next = 1'b1;
            end
        end

        job.phase     = phase_next;
        job.connected = conn_next;
        job.ip        = ip_next;
        job.port      = port_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            greet_done_reg <= 1'b0;
            auth_done_reg  <= 1'b0;
            req_done_reg   <= 1'b0;
            conn_reg       <= 1'b0;
            ip_reg         <= '0;
            port_reg       <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            greet_done_reg <= greet_done_next;
            auth_done_reg  <= auth_done_next;
            req_done_reg   <= req_done_next;
            conn_reg       <= conn_next;
            ip_reg         <= ip_next;
            port_reg       <= port_next;
        end
    end

`ifndef SYNTHESIS
    // Connected only ever holds in the established phase
    a_conn_est: assert property (@(posedge clk) disable iff (!rst_n)
        conn_reg |-> (phase_reg == PH_EST))
        else $error("connected flag outside established phase");

    // Leaving idle needs the greeting first
    a_greet_first: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> greet_done_reg)
        else $error("phase left idle without greeting");

    // Auth frame never precedes the greeting
    a_auth_order: assert property (@(posedge clk) disable iff (!rst_n)
        auth_done_reg |-> greet_done_reg)
        else $error("auth frame sent before greeting");

    // Once the connect frame is out the handshake is past auth
    a_req_phase: assert property (@(posedge clk) disable iff (!rst_n)
        req_done_reg |-> (phase_reg == PH_REQ || phase_reg == PH_EST ||
                          phase_reg == PH_ERR))
        else $error("connect frame sent but phase went back");
`endif

endmodule

// ----- src/socks_fifo.sv -----
`timescale 1ns / 1ps
// Short job queue between the front end and the frame serialiser.
// Depends on socks_pkg for the job type and depth.
module socks_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  socks_pkg::job_t  push_data,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output socks_pkg::job_t  head
);
    import socks_pkg::*;

    localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);

    job_t             mem_reg [JOB_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(JOB_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- src/socks_back.sv -----
`timescale 1ns / 1ps
// Back end: takes queued jobs and sends the frame one byte per beat,
// or a single report beat when there is no frame. Depends on socks_pkg.
module socks_back (
    input  logic                 clk,
    input  logic                 rst_n,
    socks_stream_if.source       res,
    input  socks_pkg::cfg_regs_t regs,
    input  logic                 empty,
    input  socks_pkg::job_t      head,
    output logic                 pop
);
    import socks_pkg::*;

    logic       busy_reg, busy_next;
    job_t       job_reg, job_next;
    logic [5:0] k_reg, k_next;
    logic [5:0] last_reg, last_next;

    logic         done;
    logic [4:0]   ul;
    logic [4:0]   pl;
    logic [5:0]   ul_end;
    logic [5:0]   u_idx_w;
    logic [5:0]   p_idx_w;
    logic [3:0]   u_idx;
    logic [3:0]   p_idx;
    logic [127:0] user_all;
    logic [127:0] pass_all;
    logic [7:0]   frame_byte;

    assign ul       = clamp_len(regs.user_len);
    assign pl       = clamp_len(regs.pass_len);
    assign ul_end   = {1'b0, ul} + 6'd2;
    assign u_idx_w  = k_reg - 6'd2;
    assign p_idx_w  = k_reg - ul_end - 6'd1;
    assign u_idx    = u_idx_w[3:0];
    assign p_idx    = p_idx_w[3:0];
    assign user_all = {regs.user_hi, regs.user_lo};
    assign pass_all = {regs.pass_hi, regs.pass_lo};

    assign done = res.valid && res.ready && (k_reg == last_reg);
    assign pop  = !empty && (!busy_reg || done);

    // Byte at the current position of the frame
    always_comb
    begin
        frame_byte = B_ZERO;
        case (job_reg.kind)
            K_GREET:
            begin
                case (k_reg)
                    6'd0:    frame_byte = B_VER5;
                    6'd1:    frame_byte = regs.auth_offered ? B_TWO : B_ONE;
                    6'd2:    frame_byte = B_ZERO;
                    default: frame_byte = B_TWO;
                endcase
            end
            K_CONN:
            begin
                case (k_reg)
                    6'd0:    frame_byte = B_VER5;
                    6'd1:    frame_byte = B_ONE;
                    6'd2:    frame_byte = B_ZERO;
                    6'd3:    frame_byte = B_ONE;
                    6'd4:    frame_byte = job_reg.ip[31:24];
                    6'd5:    frame_byte = job_reg.ip[23:16];
                    6'd6:    frame_byte = job_reg.ip[15:8];
                    6'd7:    frame_byte = job_reg.ip[7:0];
                    6'd8:    frame_byte = job_reg.port[15:8];
                    default: frame_byte = job_reg.port[7:0];
                endcase
            end
            K_AUTH:
            begin
                if (k_reg == 6'd0)
                    frame_byte = B_ONE;
                else if (k_reg == 6'd1)
                    frame_byte = {3'b000, ul};
                else if (k_reg < ul_end)
                    frame_byte = user_all[{u_idx, 3'b000} +: 8];
                else if (k_reg == ul_end)
                    frame_byte = {3'b000, pl};
                else
                    frame_byte = pass_all[{p_idx, 3'b000} +: 8];
            end
            default: frame_byte = B_ZERO;
        endcase
    end

    // Output beat
    assign res.valid          = busy_reg;
    assign res.data.tx_valid  = (job_reg.kind != K_NONE);
    assign res.data.tx_byte   = frame_byte;
    assign res.data.tx_last   = (k_reg == last_reg);
    assign res.data.status    = job_reg.status;
    assign res.data.phase     = job_reg.phase;
    assign res.data.connected = job_reg.connected;

    // Sequencer: load a job, step through its beats
    always_comb
    begin
        busy_next = busy_reg;
        job_next  = job_reg;
        k_next    = k_reg;
        last_next = last_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            job_next  = head;
            k_next    = '0;
            case (head.kind)
                K_GREET: last_next = regs.auth_offered ? 6'd3 : 6'd2;
                K_CONN:  last_next = 6'd9;
                K_AUTH:  last_next = {1'b0, ul} + {1'b0, pl} + 6'd2;
                default: last_next = 6'd0;
            endcase
        end
        else if (done)
            busy_next = 1'b0;
        else if (res.valid && res.ready)
            k_next = k_reg + 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
            last_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

`ifndef SYNTHESIS
    // A report-only beat is always the last of its item
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.data.tx_valid) |-> res.data.tx_last)
        else $error("report beat without last flag");

    // Position never runs past the end of the frame
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (k_reg <= last_reg))
        else $error("frame position past end");

    // No frame is longer than the longest auth frame
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (last_reg <= 6'(MAX_BEATS - 1)))
        else $error("frame length out of range");
`endif

endmodule

// ----- src/socks5_client_handshake_top.sv -----
`timescale 1ns / 1ps
// Top level of the SOCKS5 client handshake block: register bank, front end,
// job queue and frame serialiser. Depends on socks_pkg and socks_stream_if.
//
//  channel | dir | payload   | role
//  cmd     | in  | cmd_t     | start or server-reply item
//  res     | out | res_t     | one beat per frame byte, or one report beat
//  cfg     | in  | cfg_wr_t  | register write, index and 64-bit data
//
// An item is judged and its state change made in the cycle it is accepted;
// its frame then leaves the serialiser one beat per cycle while res is ready,
// 1 to 35 beats (greeting 3-4, connect 10, auth 3 + user + password lengths).
// A two-entry job queue lets the front take items while the back stalls.
// rst_n clears control state asynchronously; no clearing pass is needed.
// A stalled res holds its beat; cmd.ready drops only while the queue is full.
module socks5_client_handshake_top (
    input  logic           clk,
    input  logic           rst_n,
    socks_stream_if.sink   cmd,
    socks_stream_if.source res,
    socks_stream_if.sink   cfg
);
    import socks_pkg::*;

    cfg_regs_t regs;
    job_t      push_job;
    job_t      head_job;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;

    socks_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    socks_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .regs  (regs),
        .full  (full),
        .push  (push),
        .job   (push_job)
    );

    socks_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head_job)
    );

    socks_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .res   (res),
        .regs  (regs),
        .empty (empty),
        .head  (head_job),
        .pop   (pop)
    );

endmodule

// ----- dv/tb_socks5_client_handshake_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for socks5_client_handshake_top: queued stimulus, predictor,
// beat-by-beat scoreboard. Depends on socks_pkg, socks_stream_if and the RTL top.
module tb_socks5_client_handshake_top;
    import socks_pkg::*;

    localparam logic MODE_REPLY    = ~MODE_START;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   CALM_TAIL     = 40;

    // One pending stimulus entry: either a command item or a register write
    typedef struct {
        logic    is_wr;
        cmd_t    cmd;
        cfg_wr_t wr;
    } stim_t;

    logic clk;
    logic rst_n = 1'b0;

    socks_stream_if #(.data_t(cmd_t))    cmd_if ();
    socks_stream_if #(.data_t(res_t))    res_if ();
    socks_stream_if #(.data_t(cfg_wr_t)) cfg_if ();

    socks5_client_handshake_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // Stimulus and scoreboard storage
    stim_t      pending[$];
    res_t       beats_due[$];
    logic [7:0] frame_q[$];

    // Predictor copy of the registers
    logic        cfg_auth_offered;
    logic [4:0]  cfg_user_len;
    logic [63:0] cfg_user_lo;
    logic [63:0] cfg_user_hi;
    logic [4:0]  cfg_pass_len;
    logic [63:0] cfg_pass_lo;
    logic [63:0] cfg_pass_hi;

    // Predictor copy of the handshake state
    logic [2:0]  m_phase;
    logic        greet_sent;
    logic        auth_frame_out;
    logic        conn_req_sent;
    logic        link_up;
    logic [31:0] dst_ip_q;
    logic [15:0] dst_port_q;

    // Driver and monitor bookkeeping
    int gap_left;
    int stall_left;
    int settle;
    logic took;
    logic drive_cmd;
    logic drive_wr;
    int errors;
    int n_starts;
    int n_replies;
    int n_wr;
    int n_beats;
    int n_frame_bytes;
    logic [7:0] status_seen;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] cred_byte(input logic [63:0] lo, input logic [63:0] hi,
                                             input int i);
        return (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
    endfunction

    function void apply_reg_write(input cfg_wr_t w);
        case (w.index)
            REG_AUTH_OFFERED: cfg_auth_offered = w.wdata[0];
            REG_USER_LEN:     cfg_user_len     = w.wdata[4:0];
            REG_USER_LO:      cfg_user_lo      = w.wdata;
            REG_USER_HI:      cfg_user_hi      = w.wdata;
            REG_PASS_LEN:     cfg_pass_len     = w.wdata[4:0];
            REG_PASS_LO:      cfg_pass_lo      = w.wdata;
            REG_PASS_HI:      cfg_pass_hi      = w.wdata;
            default: ;
        endcase
    endfunction

    // CONNECT frame for the saved IPv4 destination, sent once per reset
    function void frame_connect();
        if (!conn_req_sent)
        begin
            frame_q.push_back(B_VER5);
            frame_q.push_back(B_ONE);
            frame_q.push_back(B_ZERO);
            frame_q.push_back(B_ONE);
            for (int k = 3; k >= 0; k--)
                frame_q.push_back(dst_ip_q[8*k +: 8]);
            frame_q.push_back(dst_port_q[15:8]);
            frame_q.push_back(dst_port_q[7:0]);
            conn_req_sent = 1'b1;
            m_phase = PH_REQ;
        end
    endfunction

    // Works out the result beats of one accepted item and queues them
    function void predict_beats(input cmd_t c);
        logic [2:0] st;
        int ul;
        int pl;
        res_t beat;
        st = ST_OK;
        frame_q.delete();
        if (c.mode == MODE_START)
        begin
            dst_ip_q   = c.dst_ip;
            dst_port_q = c.dst_port_in;
            if (!greet_sent)
            begin
                frame_q.push_back(B_VER5);
                if (cfg_auth_offered)
                begin
                    frame_q.push_back(B_TWO);
                    frame_q.push_back(B_ZERO);
                    frame_q.push_back(B_TWO);
                end
                else
                begin
                    frame_q.push_back(B_ONE);
                    frame_q.push_back(B_ZERO);
                end
                greet_sent = 1'b1;
                m_phase = PH_GREET;
            end
        end
        else
        begin
            case (m_phase)
                PH_GREET:
                begin
                    if (c.rx_count < 8'd2)
                        st = ST_SHORT;
                    else if (c.rx_first != B_VER5)
                        st = ST_BAD_VER;
                    else if (c.rx_second == B_NO_ACC)
                        st = ST_NO_METHOD;
                    else if (c.rx_second == B_ZERO)
                    begin
                        m_phase = PH_REQ;
                        frame_connect();
                    end
                    else if (c.rx_second == B_TWO)
                    begin
                        m_phase = PH_AUTH;
                        // username/password frame, lengths saturated
                        if (!auth_frame_out && cfg_user_len != 5'd0)
                        begin
                            ul = (cfg_user_len > CRED_CAP) ? CRED_CAP : cfg_user_len;
                            pl = (cfg_pass_len > CRED_CAP) ? CRED_CAP : cfg_pass_len;
                            frame_q.push_back(B_ONE);
                            frame_q.push_back(8'(ul));
                            for (int i = 0; i < ul; i++)
                                frame_q.push_back(cred_byte(cfg_user_lo, cfg_user_hi, i));
                            frame_q.push_back(8'(pl));
                            for (int i = 0; i < pl; i++)
                                frame_q.push_back(cred_byte(cfg_pass_lo, cfg_pass_hi, i));
                            auth_frame_out = 1'b1;
                            m_phase = PH_AUTH;
                        end
                    end
                    else
                        st = ST_UNSUPP;
                end
                PH_AUTH:
                begin
                    if (c.rx_count < 8'd2)
                        st = ST_SHORT;
                    else if (c.rx_first != B_ONE)
                        st = ST_BAD_VER;
                    else if (c.rx_second != B_ZERO)
                        st = ST_AUTH_FAIL;
                    else
                    begin
                        m_phase = PH_REQ;
                        frame_connect();
                    end
                end
                PH_REQ:
                begin
                    if (c.rx_count < 8'd4)
                        st = ST_SHORT;
                    else if (c.rx_first != B_VER5)
                        st = ST_BAD_VER;
                    else if (c.rx_second != B_ZERO)
                    begin
                        st = ST_REFUSED;
                        m_phase = PH_ERR;
                    end
                    else
                    begin
                        m_phase = PH_EST;
                        link_up = 1'b1;
                    end
                end
                PH_EST: ;
                default: st = ST_BAD_PHASE;
            endcase
        end

        // no frame bytes: a single report beat
        beat.status    = st;
        beat.phase     = m_phase;
        beat.connected = link_up;
        if (frame_q.size() == 0)
        begin
            beat.tx_valid = 1'b0;
            beat.tx_byte  = 8'd0;
            beat.tx_last  = 1'b1;
            beats_due.push_back(beat);
        end
        else
        begin
            for (int k = 0; k < frame_q.size(); k++)
            begin
                beat.tx_valid = 1'b1;
                beat.tx_byte  = frame_q[k];
                beat.tx_last  = (k == frame_q.size() - 1);
                beats_due.push_back(beat);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function void add_start(input logic [31:0] ip, input logic [15:0] port);
        stim_t s;
        s.is_wr           = 1'b0;
        s.wr              = '0;
        s.cmd.mode        = MODE_START;
        s.cmd.rx_first    = 8'($urandom);
        s.cmd.rx_second   = 8'($urandom);
        s.cmd.rx_count    = 8'($urandom);
        s.cmd.dst_ip      = ip;
        s.cmd.dst_port_in = port;
        pending.push_back(s);
    endfunction

    function void add_reply(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] cnt);
        stim_t s;
        s.is_wr           = 1'b0;
        s.wr              = '0;
        s.cmd.mode        = MODE_REPLY;
        s.cmd.rx_first    = b0;
        s.cmd.rx_second   = b1;
        s.cmd.rx_count    = cnt;
        s.cmd.dst_ip      = $urandom;
        s.cmd.dst_port_in = 16'($urandom);
        pending.push_back(s);
    endfunction

    function void add_reg_write(input logic [2:0] idx, input logic [63:0] data);
        stim_t s;
        s.is_wr    = 1'b1;
        s.cmd      = '0;
        s.wr.index = idx;
        s.wr.wdata = data;
        pending.push_back(s);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents the head of the pending queue on cmd or cfg
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid <= 1'b0;
            cfg_if.valid <= 1'b0;
            gap_left = 0;
            settle   = 0;
        end
        else
        begin
            took = 1'b0;
            if (cmd_if.valid && cmd_if.ready)
            begin
                predict_beats(cmd_if.data);
                if (cmd_if.data.mode == MODE_START)
                    n_starts++;
                else
                    n_replies++;
                void'(pending.pop_front());
                took = 1'b1;
            end
            if (cfg_if.valid && cfg_if.ready)
            begin
                apply_reg_write(cfg_if.data);
                n_wr++;
                void'(pending.pop_front());
                took = 1'b1;
            end
            if (took && pending.size() >= CALM_TAIL && $urandom_range(0, 3) == 0)
                gap_left = $urandom_range(1, 8);

            // register writes wait until the block has drained
            if (beats_due.size() == 0)
                settle = (settle < SETTLE_CYCLES) ? settle + 1 : settle;
            else
                settle = 0;

            drive_cmd = 1'b0;
            drive_wr  = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending.size() > 0)
            begin
                if (!pending[0].is_wr)
                    drive_cmd = 1'b1;
                else if (beats_due.size() == 0 && settle >= SETTLE_CYCLES)
                    drive_wr = 1'b1;
            end
            cmd_if.valid <= drive_cmd;
            cfg_if.valid <= drive_wr;
            if (drive_cmd)
                cmd_if.data <= pending[0].cmd;
            if (drive_wr)
                cfg_if.data <= pending[0].wr;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure and beat-by-beat comparison
    // ------------------------------------------------------------------
    function void check_field(input string name, input int unsigned want,
                              input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                n_beats++;
                status_seen[res_if.data.status] = 1'b1;
                if (res_if.data.tx_valid)
                    n_frame_bytes++;
                if (beats_due.size() == 0)
                begin
                    $display("%0t ns: unexpected beat, expected none, actual %h",
                             $time, res_if.data);
                    errors++;
                end
                else
                begin
                    check_field("tx_valid", beats_due[0].tx_valid, res_if.data.tx_valid);
                    check_field("tx_byte", beats_due[0].tx_byte, res_if.data.tx_byte);
                    check_field("tx_last", beats_due[0].tx_last, res_if.data.tx_last);
                    check_field("status", beats_due[0].status, res_if.data.status);
                    check_field("phase", beats_due[0].phase, res_if.data.phase);
                    check_field("connected", beats_due[0].connected, res_if.data.connected);
                    void'(beats_due.pop_front());
                end
            end

            if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else if (pending.size() >= CALM_TAIL && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] cnt;

        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        res_if.ready = 1'b0;

        cfg_auth_offered = 1'b0;
        cfg_user_len = '0;
        cfg_user_lo  = '0;
        cfg_user_hi  = '0;
        cfg_pass_len = '0;
        cfg_pass_lo  = '0;
        cfg_pass_hi  = '0;
        m_phase        = PH_IDLE;
        greet_sent     = 1'b0;
        auth_frame_out = 1'b0;
        conn_req_sent  = 1'b0;
        link_up        = 1'b0;
        dst_ip_q       = '0;
        dst_port_q     = '0;
        errors = 0;
        n_starts = 0;
        n_replies = 0;
        n_wr = 0;
        n_beats = 0;
        n_frame_bytes = 0;
        status_seen = '0;

        // Credentials for the one auth frame: both lengths above the cap, so 35 beats
        add_reg_write(REG_AUTH_OFFERED, 64'd1);
        add_reg_write(REG_USER_LEN, 64'd31);
        add_reg_write(REG_USER_LO, {$urandom, $urandom});
        add_reg_write(REG_USER_HI, {$urandom, $urandom});
        add_reg_write(REG_PASS_LEN, 64'd17);
        add_reg_write(REG_PASS_LO, {$urandom, $urandom});
        add_reg_write(REG_PASS_HI, {$urandom, $urandom});

        // Directed walk: idle reply, greeting, every greeting and auth error,
        // auth frame, connect frame, then the short and bad-version connect errors
        add_reply(8'hFF, 8'hFF, 8'hFF);
        add_start(32'hFFFF_FFFF, 16'h0000);
        add_start(32'h0000_0000, 16'hFFFF);
        add_start($urandom, 16'($urandom));
        add_reply(B_VER5, B_ZERO, 8'd1);
        add_reply(B_VER5, B_ZERO, 8'd0);
        add_reply(8'h04, B_ZERO, 8'd2);
        add_reply(B_VER5, B_NO_ACC, 8'd2);
        add_reply(B_VER5, B_ONE, 8'd2);
        add_reply(B_VER5, 8'h80, 8'd200);
        add_reply(B_VER5, B_TWO, 8'd255);
        add_reply(B_ONE, B_ZERO, 8'd1);
        add_reply(B_VER5, B_ZERO, 8'd2);
        add_reply(B_ONE, B_ONE, 8'd2);
        add_reply(B_ONE, 8'hFF, 8'd2);
        add_start($urandom, 16'($urandom));
        add_reply(B_ONE, B_ZERO, 8'd2);
        add_reply(B_VER5, B_ZERO, 8'd3);
        add_reply(B_ZERO, B_ZERO, 8'd4);
        add_reply(8'hFF, B_ONE, 8'd255);

        // Registers no longer reach any frame, but the writes must still land
        add_reg_write(REG_AUTH_OFFERED, 64'd0);
        add_reg_write(REG_USER_LEN, 64'd0);
        add_reg_write(REG_USER_LO, 64'd0);
        add_reg_write(REG_USER_HI, 64'd0);
        add_reg_write(REG_PASS_LEN, 64'd0);
        add_reg_write(REG_PASS_LO, 64'd0);
        add_reg_write(REG_PASS_HI, 64'd0);

        // Request phase: replies that keep the connect pending, starts mixed in
        repeat (150)
        begin
            if ($urandom_range(0, 3) == 0)
                add_start($urandom, 16'($urandom));
            else
            begin
                b0  = 8'($urandom);
                b1  = 8'($urandom);
                cnt = 8'($urandom);
                if ($urandom_range(0, 2) == 0)
                begin
                    b0  = B_VER5;
                    cnt = 8'($urandom_range(0, 3));
                end
                else if (b0 == B_VER5 && cnt >= 8'd4)
                    b0 = B_VER5 ^ 8'($urandom_range(1, 255));
                add_reply(b0, b1, cnt);
            end
        end

        // Connect reply: success or refusal, the seed decides
        if ($urandom_range(0, 1) == 0)
            add_reply(B_VER5, B_ZERO, 8'($urandom_range(4, 255)));
        else
            add_reply(B_VER5, 8'($urandom_range(1, 255)), 8'($urandom_range(4, 255)));

        add_reg_write(REG_AUTH_OFFERED, 64'd1);
        add_reg_write(REG_USER_LEN, 64'd16);
        add_reg_write(REG_USER_LO, {64{1'b1}});
        add_reg_write(REG_USER_HI, {64{1'b1}});
        add_reg_write(REG_PASS_LEN, 64'd16);
        add_reg_write(REG_PASS_LO, {64{1'b1}});
        add_reg_write(REG_PASS_HI, {64{1'b1}});

        // Terminal phase: anything goes
        repeat (110)
        begin
            if ($urandom_range(0, 3) == 0)
                add_start($urandom, 16'($urandom));
            else
                add_reply(8'($urandom), 8'($urandom), 8'($urandom));
        end

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || beats_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Run covered %0d starts, %0d replies and %0d register writes.",
                 n_starts, n_replies, n_wr);
        $display("Checked %0d result beats (%0d frame bytes), status mask %b, final phase %0d.",
                 n_beats, n_frame_bytes, status_seen, m_phase);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("Timeout with %0d items pending and %0d beats owed.",
                 pending.size(), beats_due.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
src/socks_pkg.sv
src/socks_stream_if.sv
src/socks_regs.sv
src/socks_front.sv
src/socks_fifo.sv
src/socks_back.sv
src/socks5_client_handshake_top.sv
dv/tb_socks5_client_handshake_top.sv
